// ===== hdl/i2cm_pkg.sv =====
// i2cm_pkg: shared types and constants of the i2c master controller
// used by i2cm_seq and i2c_master_controller_unit; no dependencies
`default_nettype none

package i2cm_pkg;

   // stream widths
   localparam int ReqDataWidth = 32;
   localparam int ReqUserWidth = 2;
   localparam int RspDataWidth = 16;
   localparam int CsrDataWidth = 8;

   // action codes
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_LOAD  = 2'd3;

   // reset value of the acknowledge timeout limit
   localparam logic [7:0] ACK_LIMIT_RESET = 8'd250;

   // bit of the shift register that goes out first
   localparam int MsbBit = 7;

   // one result item
   typedef struct packed {
      logic       failed;
      logic       done_res;
      logic       busy_res;
      logic       data_request;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       sda_level;
      logic       scl_level;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/i2cm_seq.sv =====
// i2cm_seq: bus phase sequencer, one phase per accepted item
// holds the transfer state; depends on i2cm_pkg
`default_nettype none

module i2cm_seq (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [1:0]       action,
   input  wire logic [7:0]       address_byte,
   input  wire logic [7:0]       transfer_length,
   input  wire logic [7:0]       write_byte,
   input  wire logic             sda_in,
   input  wire logic [7:0]       ack_limit,
   output i2cm_pkg::rsp_type     res
);
   import i2cm_pkg::*;

   // phase codes
   localparam logic [4:0] PH_IDLE   = 5'd0;
   localparam logic [4:0] PH_ST_B   = 5'd1;
   localparam logic [4:0] PH_ST_C   = 5'd2;
   localparam logic [4:0] PH_TX_SET = 5'd3;
   localparam logic [4:0] PH_TX_HI  = 5'd4;
   localparam logic [4:0] PH_TX_LO  = 5'd5;
   localparam logic [4:0] PH_AK_REL = 5'd6;
   localparam logic [4:0] PH_AK_HI  = 5'd7;
   localparam logic [4:0] PH_AK_SMP = 5'd8;
   localparam logic [4:0] PH_AK_LO  = 5'd9;
   localparam logic [4:0] PH_WAIT   = 5'd10;
   localparam logic [4:0] PH_RX_LO  = 5'd11;
   localparam logic [4:0] PH_RX_HI  = 5'd12;
   localparam logic [4:0] PH_MA_LO  = 5'd13;
   localparam logic [4:0] PH_MA_HI  = 5'd14;
   localparam logic [4:0] PH_MA_END = 5'd15;
   localparam logic [4:0] PH_SP_A   = 5'd16;
   localparam logic [4:0] PH_SP_B   = 5'd17;

   logic [4:0] phase_ff, phase_in;
   logic [7:0] shreg_ff, shreg_in;
   logic [3:0] bitcnt_ff, bitcnt_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [8:0] tocnt_ff, tocnt_in;
   logic       reading_ff, reading_in;
   logic       acklvl_ff, acklvl_in;
   logic       fail_ff, fail_in;

   logic [4:0] cur_phase;
   logic [7:0] cur_shreg;
   logic [3:0] cur_bitcnt;
   logic [7:0] rx_shift;
   logic [3:0] bit_inc;
   logic [7:0] rem_dec;
   logic [8:0] tocnt_inc;

   // a loaded byte while waiting starts the bit phase in the same step
   always_comb begin
      if (phase_ff == PH_WAIT && action == ACT_LOAD) begin
         cur_phase  = PH_TX_SET;
         cur_shreg  = write_byte;
         cur_bitcnt = 4'd0;
      end else begin
         cur_phase  = phase_ff;
         cur_shreg  = shreg_ff;
         cur_bitcnt = bitcnt_ff;
      end
   end

   assign rx_shift  = {cur_shreg[6:0], sda_in};
   assign bit_inc   = cur_bitcnt + 4'd1;
   assign rem_dec   = remaining_ff - 8'd1;
   assign tocnt_inc = tocnt_ff + 9'd1;

   // phase step: line levels and next state
   always_comb begin
      phase_in     = cur_phase;
      shreg_in     = cur_shreg;
      bitcnt_in    = cur_bitcnt;
      remaining_in = remaining_ff;
      tocnt_in     = tocnt_ff;
      reading_in   = reading_ff;
      acklvl_in    = acklvl_ff;
      fail_in      = fail_ff;
      res          = '0;
      res.scl_level = 1'b1;
      res.sda_level = 1'b1;
      case (cur_phase)
         PH_IDLE: begin
            if (action == ACT_WRITE || action == ACT_READ) begin
               reading_in   = (action == ACT_READ);
               shreg_in     = (action == ACT_READ) ? address_byte + 8'd1 : address_byte;
               remaining_in = transfer_length;
               bitcnt_in    = 4'd0;
               fail_in      = 1'b0;
               phase_in     = PH_ST_B;
            end
         end
         PH_ST_B: begin
            res.sda_level = 1'b0;
            phase_in      = PH_ST_C;
         end
         PH_ST_C: begin
            res.scl_level = 1'b0;
            res.sda_level = 1'b0;
            phase_in      = PH_TX_SET;
         end
         PH_TX_SET: begin
            res.scl_level = 1'b0;
            res.sda_level = cur_shreg[MsbBit];
            phase_in      = PH_TX_HI;
         end
         PH_TX_HI: begin
            res.sda_level = cur_shreg[MsbBit];
            phase_in      = PH_TX_LO;
         end
         PH_TX_LO: begin
            res.scl_level = 1'b0;
            res.sda_level = cur_shreg[MsbBit];
            shreg_in      = {cur_shreg[6:0], 1'b0};
            bitcnt_in     = bit_inc;
            phase_in      = (bit_inc >= 4'd8) ? PH_AK_REL : PH_TX_SET;
         end
         PH_AK_REL: begin
            res.scl_level = 1'b0;
            tocnt_in      = 9'd0;
            phase_in      = PH_AK_HI;
         end
         PH_AK_HI: begin
            phase_in = PH_AK_SMP;
         end
         PH_AK_SMP: begin
            // slave holds sda low for ack; count high samples otherwise
            if (!sda_in) begin
               phase_in = PH_AK_LO;
            end else begin
               tocnt_in = tocnt_inc;
               if (tocnt_inc > {1'b0, ack_limit}) begin
                  fail_in  = 1'b1;
                  phase_in = PH_SP_A;
               end
            end
         end
         PH_AK_LO: begin
            res.scl_level = 1'b0;
            if (remaining_ff == 8'd0) begin
               phase_in = PH_SP_A;
            end else if (reading_ff) begin
               bitcnt_in = 4'd0;
               shreg_in  = 8'd0;
               phase_in  = PH_RX_LO;
            end else begin
               remaining_in = rem_dec;
               phase_in     = PH_WAIT;
            end
         end
         PH_WAIT: begin
            res.scl_level = 1'b0;
         end
         PH_RX_LO: begin
            res.scl_level = 1'b0;
            phase_in      = PH_RX_HI;
         end
         PH_RX_HI: begin
            shreg_in  = rx_shift;
            bitcnt_in = bit_inc;
            if (bit_inc >= 4'd8) begin
               res.read_valid = 1'b1;
               res.read_byte  = rx_shift;
               remaining_in   = rem_dec;
               acklvl_in      = (rem_dec == 8'd0);
               phase_in       = PH_MA_LO;
            end else begin
               phase_in = PH_RX_LO;
            end
         end
         PH_MA_LO: begin
            res.scl_level = 1'b0;
            res.sda_level = acklvl_ff;
            phase_in      = PH_MA_HI;
         end
         PH_MA_HI: begin
            res.sda_level = acklvl_ff;
            phase_in      = PH_MA_END;
         end
         PH_MA_END: begin
            res.scl_level = 1'b0;
            res.sda_level = acklvl_ff;
            if (remaining_ff == 8'd0) begin
               phase_in = PH_SP_A;
            end else begin
               bitcnt_in = 4'd0;
               shreg_in  = 8'd0;
               phase_in  = PH_RX_LO;
            end
         end
         PH_SP_A: begin
            res.scl_level = 1'b0;
            res.sda_level = 1'b0;
            phase_in      = PH_SP_B;
         end
         PH_SP_B: begin
            res.done_res = 1'b1;
            res.failed   = fail_ff;
            fail_in      = 1'b0;
            phase_in     = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      res.data_request = (phase_in == PH_WAIT);
      res.busy_res     = (phase_in != PH_IDLE);
   end

   // state registers advance once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         shreg_ff     <= 8'd0;
         bitcnt_ff    <= 4'd0;
         remaining_ff <= 8'd0;
         tocnt_ff     <= 9'd0;
         reading_ff   <= 1'b0;
         acklvl_ff    <= 1'b0;
         fail_ff      <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         shreg_ff     <= shreg_in;
         bitcnt_ff    <= bitcnt_in;
         remaining_ff <= remaining_in;
         tocnt_ff     <= tocnt_in;
         reading_ff   <= reading_in;
         acklvl_ff    <= acklvl_in;
         fail_ff      <= fail_in;
      end
   end

   // checks
   a_fail_with_done: assert property (@(posedge clock) disable iff (reset)
      step && res.failed |-> res.done_res)
      else $error("failure flagged without stop");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      step && res.done_res |-> !res.busy_res)
      else $error("busy still set after stop");

   a_read_in_transfer: assert property (@(posedge clock) disable iff (reset)
      step && res.read_valid |-> res.busy_res && !res.data_request)
      else $error("read byte outside a read transfer");

   a_timeout_bound: assert property (@(posedge clock) disable iff (reset)
      tocnt_ff <= 9'd256)
      else $error("timeout count ran past its bound");

   a_bitcnt_bound: assert property (@(posedge clock) disable iff (reset)
      step && bitcnt_in > 4'd8 |-> 1'b0)
      else $error("bit count past one byte");

endmodule

`default_nettype wire

// ===== hdl/i2c_master_controller_unit.sv =====
// i2c_master_controller_unit: top level of the i2c master controller
// wraps i2cm_seq with stream handshakes and the csr; depends on i2cm_pkg
// result: the result item for an accepted item is registered and shown in the cycle after it is accepted
// throughput: one item per cycle while results are taken; the result register is refilled as it is taken
// reset: synchronous, clears the phase sequencer to idle, empties the result
// register and sets the acknowledge timeout limit to 250
`default_nettype none

module i2c_master_controller_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: address_byte[7:0], transfer_length[15:8], write_byte[23:16], sda_in[24]
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [i2cm_pkg::ReqDataWidth-1:0]   req_tdata,
   // req_tuser: action[1:0]
   input  wire logic [i2cm_pkg::ReqUserWidth-1:0]   req_tuser,
   // rsp_tdata: scl_level[0], sda_level[1], read_byte[9:2], read_valid[10],
   // data_request[11], busy_res[12], done_res[13], failed[14]
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [i2cm_pkg::RspDataWidth-1:0]        rsp_tdata,
   // csr_data: ack_timeout_limit[7:0]
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [i2cm_pkg::CsrDataWidth-1:0]   csr_data
);
   import i2cm_pkg::*;

   logic       step;
   logic [7:0] limit_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   rsp_type    res;

   // take an item whenever the result register is free or being emptied
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // timeout limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ACK_LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   i2cm_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .action          (req_tuser[1:0]),
      .address_byte    (req_tdata[7:0]),
      .transfer_length (req_tdata[15:8]),
      .write_byte      (req_tdata[23:16]),
      .sda_in          (req_tdata[24]),
      .ack_limit       (limit_ff),
      .res             (res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

   // checks
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !step)
      else $error("item accepted over a held result");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("accepted item left no result");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[15])
      else $error("padding bit set");

endmodule

`default_nettype wire

// ===== bench/i2cm_bus_checker.sv =====
// i2cm_bus_checker: watches the item, result and csr channels of the i2c master
// controller, predicts every result item and compares it field by field
// depends on i2cm_pkg for the action codes and the result layout

module i2cm_bus_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   input  wire logic                                req_tready,
   // req_tdata: address_byte[7:0], transfer_length[15:8], write_byte[23:16], sda_in[24]
   input  wire logic [i2cm_pkg::ReqDataWidth-1:0]   req_tdata,
   // req_tuser: action[1:0]
   input  wire logic [i2cm_pkg::ReqUserWidth-1:0]   req_tuser,
   input  wire logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // rsp_tdata: scl_level[0], sda_level[1], read_byte[9:2], read_valid[10],
   // data_request[11], busy_res[12], done_res[13], failed[14]
   input  wire logic [i2cm_pkg::RspDataWidth-1:0]   rsp_tdata,
   input  wire logic                                csr_valid,
   input  wire logic                                csr_ready,
   // csr_data: ack_timeout_limit[7:0]
   input  wire logic [i2cm_pkg::CsrDataWidth-1:0]   csr_data,
   input  wire logic                                drained,
   output int                                       fail_count
);

   import i2cm_pkg::*;

   typedef enum logic [4:0] {
      BUS_IDLE, BUS_START_B, BUS_START_C, BUS_TX_SET, BUS_TX_HIGH, BUS_TX_LOW,
      BUS_ACK_REL, BUS_ACK_HIGH, BUS_ACK_SAMPLE, BUS_ACK_LOW, BUS_WAIT_BYTE,
      BUS_RX_LOW, BUS_RX_HIGH, BUS_MACK_LOW, BUS_MACK_HIGH, BUS_MACK_END,
      BUS_STOP_A, BUS_STOP_B
   } bus_phase_type;

   // own copy of the sequencer state and the csr
   bus_phase_type phase;
   logic [7:0]  shifter;
   logic [3:0]  bit_count;
   logic [7:0]  bytes_left;
   logic [15:0] ack_highs;
   logic        read_mode;
   logic        ack_level;
   logic        timed_out;
   logic [7:0]  ack_limit;

   rsp_type     pending_bus_states[$];
   rsp_type     got_item;
   rsp_type     want_item;
   int          mismatches = 0;
   bit          leftover_flagged = 1'b0;

   assign fail_count = mismatches;

   // one bus phase per accepted item, returns the line levels and flags it gives
   function automatic rsp_type advance_bus(input logic [1:0] action, input logic [7:0] addr,
                                           input logic [7:0] len, input logic [7:0] wbyte,
                                           input logic sda);
      rsp_type       r;
      bus_phase_type nxt;
      r = '0;
      r.scl_level = 1'b1;
      r.sda_level = 1'b1;
      nxt = phase;

      // a byte loaded while waiting goes straight to the first bit
      if (phase == BUS_WAIT_BYTE && action == ACT_LOAD) begin
         shifter = wbyte;
         bit_count = '0;
         phase = BUS_TX_SET;
      end

      case (phase)
         BUS_IDLE: begin
            if (action == ACT_WRITE || action == ACT_READ) begin
               read_mode = (action == ACT_READ);
               shifter = read_mode ? addr + 8'd1 : addr;
               bytes_left = len;
               bit_count = '0;
               timed_out = 1'b0;
               nxt = BUS_START_B;
            end
         end
         BUS_START_B: begin
            r.sda_level = 1'b0;
            nxt = BUS_START_C;
         end
         BUS_START_C: begin
            r.scl_level = 1'b0;
            r.sda_level = 1'b0;
            nxt = BUS_TX_SET;
         end
         BUS_TX_SET: begin
            r.scl_level = 1'b0;
            r.sda_level = shifter[MsbBit];
            nxt = BUS_TX_HIGH;
         end
         BUS_TX_HIGH: begin
            r.sda_level = shifter[MsbBit];
            nxt = BUS_TX_LOW;
         end
         BUS_TX_LOW: begin
            r.scl_level = 1'b0;
            r.sda_level = shifter[MsbBit];
            shifter = shifter << 1;
            bit_count = bit_count + 4'd1;
            nxt = (bit_count >= 4'd8) ? BUS_ACK_REL : BUS_TX_SET;
         end
         BUS_ACK_REL: begin
            r.scl_level = 1'b0;
            ack_highs = '0;
            nxt = BUS_ACK_HIGH;
         end
         BUS_ACK_HIGH: nxt = BUS_ACK_SAMPLE;
         BUS_ACK_SAMPLE: begin
            if (!sda) begin
               nxt = BUS_ACK_LOW;
            end else begin
               ack_highs = ack_highs + 16'd1;
               if (ack_highs > {8'd0, ack_limit}) begin
                  timed_out = 1'b1;
                  nxt = BUS_STOP_A;
               end
            end
         end
         BUS_ACK_LOW: begin
            r.scl_level = 1'b0;
            if (bytes_left == 8'd0) begin
               nxt = BUS_STOP_A;
            end else if (read_mode) begin
               bit_count = '0;
               shifter = '0;
               nxt = BUS_RX_LOW;
            end else begin
               bytes_left = bytes_left - 8'd1;
               nxt = BUS_WAIT_BYTE;
            end
         end
         BUS_WAIT_BYTE: r.scl_level = 1'b0;
         BUS_RX_LOW: begin
            r.scl_level = 1'b0;
            nxt = BUS_RX_HIGH;
         end
         BUS_RX_HIGH: begin
            shifter = {shifter[6:0], sda};
            bit_count = bit_count + 4'd1;
            if (bit_count >= 4'd8) begin
               r.read_valid = 1'b1;
               r.read_byte = shifter;
               bytes_left = bytes_left - 8'd1;
               ack_level = (bytes_left == 8'd0);
               nxt = BUS_MACK_LOW;
            end else begin
               nxt = BUS_RX_LOW;
            end
         end
         BUS_MACK_LOW: begin
            r.scl_level = 1'b0;
            r.sda_level = ack_level;
            nxt = BUS_MACK_HIGH;
         end
         BUS_MACK_HIGH: begin
            r.sda_level = ack_level;
            nxt = BUS_MACK_END;
         end
         BUS_MACK_END: begin
            r.scl_level = 1'b0;
            r.sda_level = ack_level;
            if (bytes_left == 8'd0) begin
               nxt = BUS_STOP_A;
            end else begin
               bit_count = '0;
               shifter = '0;
               nxt = BUS_RX_LOW;
            end
         end
         BUS_STOP_A: begin
            r.scl_level = 1'b0;
            r.sda_level = 1'b0;
            nxt = BUS_STOP_B;
         end
         BUS_STOP_B: begin
            r.done_res = 1'b1;
            r.failed = timed_out;
            timed_out = 1'b0;
            nxt = BUS_IDLE;
         end
         default: nxt = BUS_IDLE;
      endcase

      phase = nxt;
      r.data_request = (phase == BUS_WAIT_BYTE);
      r.busy_res = (phase != BUS_IDLE);
      return r;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endfunction

   // results first: an item taken at this edge cannot have its result out yet
   always @(posedge clock) begin
      if (reset) begin
         phase = BUS_IDLE;
         shifter = '0;
         bit_count = '0;
         bytes_left = '0;
         ack_highs = '0;
         read_mode = 1'b0;
         ack_level = 1'b0;
         timed_out = 1'b0;
         ack_limit = ACK_LIMIT_RESET;
         pending_bus_states.delete();
      end else begin
         if (csr_valid && csr_ready)
            ack_limit = csr_data;

         // compare against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got_item = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
            if (pending_bus_states.size() == 0) begin
               $error("result item with no expectation waiting: %h", rsp_tdata);
               mismatches++;
            end else begin
               want_item = pending_bus_states.pop_front();
               check_field("scl_level", want_item.scl_level, got_item.scl_level);
               check_field("sda_level", want_item.sda_level, got_item.sda_level);
               check_field("read_byte", want_item.read_byte, got_item.read_byte);
               check_field("read_valid", want_item.read_valid, got_item.read_valid);
               check_field("data_request", want_item.data_request, got_item.data_request);
               check_field("busy_res", want_item.busy_res, got_item.busy_res);
               check_field("done_res", want_item.done_res, got_item.done_res);
               check_field("failed", want_item.failed, got_item.failed);
            end
         end

         // predict the result of each accepted item
         if (req_tvalid && req_tready)
            pending_bus_states.push_back(advance_bus(req_tuser, req_tdata[7:0], req_tdata[15:8],
                                                     req_tdata[23:16], req_tdata[24]));

         // expectations still waiting once the run has drained
         if (drained && !leftover_flagged && pending_bus_states.size() != 0) begin
            $error("%0d expected result items never arrived", pending_bus_states.size());
            mismatches++;
            leftover_flagged = 1'b1;
         end
      end
   end

endmodule

// ===== bench/tb_i2c_master_controller_unit.sv =====
// tb_i2c_master_controller_unit: stimulus and verdict for the i2c master controller
// drives directed and random transfers under varying idling and csr settings
// depends on i2cm_pkg, i2c_master_controller_unit and i2cm_bus_checker

module tb_i2c_master_controller_unit;

   import i2cm_pkg::*;

   localparam int CycleLimit   = 500000;
   localparam int SettleCycles = 4;
   localparam int HoldCycles   = 200;
   localparam int StageItems   = 30;

   typedef enum {SDA_LOW, SDA_STEADY, SDA_NOISY, SDA_STUCK} sda_mode_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [ReqDataWidth-1:0]    req_tdata;
   logic [ReqUserWidth-1:0]    req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RspDataWidth-1:0]    rsp_tdata;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CsrDataWidth-1:0]    csr_data;
   logic                       drained;
   int                         fail_count;

   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   bit      hold_pending = 1'b0;
   int      req_sent = 0;
   int      rsp_seen = 0;
   int      done_seen = 0;
   bit      last_busy = 1'b0;
   int      cycles = 0;
   rsp_type seen_item;

   i2c_master_controller_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   i2cm_bus_checker u_bus_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .drained    (drained),
      .fail_count (fail_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run guard
   initial begin
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   // handshake tallies used to pace the stimulus
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            req_sent <= req_sent + 1;
         if (rsp_tvalid && rsp_tready) begin
            seen_item = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
            rsp_seen <= rsp_seen + 1;
            last_busy <= seen_item.busy_res;
            if (seen_item.done_res)
               done_seen <= done_seen + 1;
         end
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HoldCycles - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic pick_sda(input sda_mode_type mode);
      case (mode)
         SDA_LOW:    return 1'b0;
         SDA_STEADY: return ($urandom_range(0, 99) < 30);
         SDA_NOISY:  return 1'($urandom_range(0, 1));
         default:    return 1'b1;
      endcase
   endfunction

   function automatic logic [7:0] pick_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return 8'($urandom_range(0, 2));
      else if (roll < 95)
         return 8'($urandom_range(3, 6));
      else
         return 8'($urandom_range(7, 15));
   endfunction

   // offer one item, return at the falling edge after it is taken
   task automatic send_item(input logic [1:0] act, input logic [7:0] addr,
                            input logic [7:0] len, input logic [7:0] wb, input logic sda);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'd0, sda, wb, len, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // one transfer: a start, then ticks, loads and stray starts until a stop is seen
   task automatic run_transfer(input logic [1:0] kind, input logic [7:0] addr,
                               input logic [7:0] len, input sda_mode_type mode, input int wfix);
      int         done_mark;
      int         roll;
      logic [1:0] act;
      logic [7:0] wb;
      logic [7:0] len_field;
      // idle noise the block ignores
      repeat ($urandom_range(0, 2))
         send_item($urandom_range(0, 1) ? ACT_TICK : ACT_LOAD, 8'($urandom), 8'($urandom),
                   8'($urandom), 1'($urandom));
      done_mark = done_seen;
      send_item(kind, addr, len, 8'($urandom), pick_sda(mode));
      while (done_seen == done_mark) begin
         roll = $urandom_range(0, 99);
         if (roll < 8)
            act = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
         else if (kind == ACT_WRITE)
            act = (roll < 65) ? ACT_LOAD : ACT_TICK;
         else
            act = (roll < 75) ? ACT_TICK : ACT_LOAD;
         // a start slipping in after the stop stays a short transfer
         len_field = (act == ACT_WRITE || act == ACT_READ) ? 8'($urandom_range(0, 3))
                                                            : 8'($urandom);
         wb = (wfix < 0) ? 8'($urandom) : 8'(wfix);
         send_item(act, 8'($urandom), len_field, wb, pick_sda(mode));
      end
   endtask

   // wait for every result, finishing any stray transfer with loads
   task automatic settle();
      while (last_busy || rsp_seen != req_sent) begin
         if (last_busy && rsp_seen == req_sent) begin
            send_item(ACT_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
         end else begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b0;
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_stage(input int items);
      int           mark;
      int           roll;
      sda_mode_type mode;
      mark = req_sent;
      while (req_sent - mark < items) begin
         roll = $urandom_range(0, 99);
         if (roll < 10)
            mode = SDA_STUCK;
         else if (roll < 40)
            mode = SDA_NOISY;
         else
            mode = SDA_STEADY;
         run_transfer($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, 8'($urandom),
                      pick_length(), mode, -1);
      end
   endtask

   // stimulus and verdict
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACT_TICK;
      csr_valid  = 1'b0;
      csr_data   = '0;
      drained    = 1'b0;
      send_idle_pct = 20;
      recv_idle_pct = 76;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: limit of zero, zero length, extreme bytes, address wrap, timeouts
      write_limit(8'd0);
      run_transfer(ACT_WRITE, 8'h00, 8'd0, SDA_LOW, 0);
      run_transfer(ACT_WRITE, 8'hFF, 8'd1, SDA_LOW, 8'hFF);
      run_transfer(ACT_WRITE, 8'h5A, 8'd1, SDA_LOW, 8'h00);
      run_transfer(ACT_READ, 8'hFF, 8'd2, SDA_LOW, -1);
      run_transfer(ACT_READ, 8'h80, 8'd1, SDA_STUCK, -1);
      settle();

      // sender idles a little, receiver a lot, widest limit
      write_limit(8'd255);
      run_transfer(ACT_WRITE, 8'($urandom), 8'd1, SDA_STUCK, -1);
      random_stage(StageItems);
      settle();

      // the other way round, tightest non-zero limit
      send_idle_pct = 76;
      recv_idle_pct = 20;
      write_limit(8'd1);
      random_stage(StageItems);
      settle();

      // no idling, with one long receiver hold-off
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_limit(8'($urandom_range(2, 254)));
      hold_pending = 1'b1;
      random_stage(StageItems);
      run_transfer(ACT_READ, 8'($urandom), 8'd3, SDA_NOISY, -1);
      settle();

      drained <= 1'b1;
      repeat (2) @(negedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
